### hdl/dnlf_pkg.sv
package dnlf_pkg;

  localparam int NUM_DIGITS  = 10;
  // two-entry queue, power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] ROW1_OFFSET = 8'h40;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_POINT  = 8'h2E;

  // one classified request with all of its digits, digits[k-1] holds digit k
  typedef struct packed {
    logic                           row;
    logic [3:0]                     column;
    logic [3:0]                     ndig;
    logic [1:0]                     point;
    logic                           zlead;
    logic [NUM_DIGITS-1:0][7:0]     digits;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [31:0] pow10(input logic [3:0] e);
    case (e)
      4'd0:    return 32'd1;
      4'd1:    return 32'd10;
      4'd2:    return 32'd100;
      4'd3:    return 32'd1000;
      4'd4:    return 32'd10000;
      4'd5:    return 32'd100000;
      4'd6:    return 32'd1000000;
      4'd7:    return 32'd10000000;
      4'd8:    return 32'd100000000;
      4'd9:    return 32'd1000000000;
      default: return 32'd1;
    endcase
  endfunction

endpackage

### hdl/dnlf_front.sv
module dnlf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_row,
  input  logic [3:0]        in_column,
  input  logic [3:0]        in_digit_count,
  input  logic [1:0]        in_point_position,
  input  logic              in_show_leading_zeros,
  input  logic [31:0]       in_value,
  input  dnlf_pkg::qstat_t  q_stat,
  output logic              q_wr,
  output dnlf_pkg::entry_t  q_entry
);
  import dnlf_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [3:0] MAX_DIG = 4'(NUM_DIGITS);

  logic [1:0]  state_r, state_nxt;
  entry_t      ent_r, ent_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  top_r, top_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [1:0]  bit_r, bit_nxt;
  logic [3:0]  acc_r, acc_nxt;

  logic [3:0]  ndig_in;
  logic [34:0] low_div;
  logic        low_ge;
  logic [3:0]  acc_new;
  logic [7:0]  top_sum;
  logic [3:0]  dig_idx;

  assign full    = (state_r != F_IDLE);
  assign q_wr    = (state_r == F_PUSH) && !q_stat.full;
  assign q_entry = ent_r;

  always_comb begin
    ndig_in   = (in_digit_count == 4'd0 || in_digit_count > MAX_DIG) ? MAX_DIG
                                                                      : in_digit_count;
    low_div = {3'b000, pow10(k_r - 4'd1)} << bit_r;
    low_ge  = ({3'b000, rem_r} >= low_div);
    acc_new = {acc_r[2:0], low_ge};
    // quotient by the top digit's weight, low byte only, built from the digits above it
    top_sum = {top_r[4:0], 3'b000} + {top_r[6:0], 1'b0} + {4'd0, acc_new};
    dig_idx = k_r - 4'd1;
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    rem_nxt   = rem_r;
    top_nxt   = top_r;
    k_nxt     = k_r;
    bit_nxt   = bit_r;
    acc_nxt   = acc_r;
    case (state_r)
      F_IDLE: begin
        if (push) begin
          ent_nxt.row    = in_row;
          ent_nxt.column = in_column;
          ent_nxt.ndig   = ndig_in;
          ent_nxt.point  = in_point_position;
          ent_nxt.zlead  = in_show_leading_zeros;
          rem_nxt        = in_value;
          top_nxt        = 8'd0;
          k_nxt          = MAX_DIG;
          bit_nxt        = 2'd3;
          acc_nxt        = 4'd0;
          state_nxt      = F_CONV;
        end
      end
      F_CONV: begin
        // every decimal digit is 0..9, four compare and subtract steps each
        rem_nxt = low_ge ? 32'({3'b000, rem_r} - low_div) : rem_r;
        acc_nxt = acc_new;
        bit_nxt = bit_r - 2'd1;
        if (bit_r == 2'd0) begin
          ent_nxt.digits[dig_idx] = (k_r == ent_r.ndig) ? top_sum : {4'd0, acc_new};
          top_nxt = top_sum;
          k_nxt   = dig_idx;
          acc_nxt = 4'd0;
          bit_nxt = 2'd3;
          if (k_r == 4'd1) begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ent_r <= ent_nxt;
    rem_r <= rem_nxt;
    top_r <= top_nxt;
    k_r   <= k_nxt;
    bit_r <= bit_nxt;
    acc_r <= acc_nxt;
  end

endmodule

### hdl/dnlf_queue.sv
module dnlf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  dnlf_pkg::entry_t  wr_data,
  input  logic              rd,
  output dnlf_pkg::entry_t  rd_data,
  output dnlf_pkg::qstat_t  stat
);
  import dnlf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  always_comb begin
    stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
    stat.empty = (cnt_r == '0);
    do_wr      = wr && !stat.full;
    do_rd      = rd && !stat.empty;
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/dnlf_back.sv
module dnlf_back #(
  parameter int LINE_WIDTH          = 16,
  parameter int SET_ADDRESS_COMMAND = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dnlf_pkg::entry_t  q_data,
  input  dnlf_pkg::qstat_t  q_stat,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic              out_is_command,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import dnlf_pkg::*;

  // position counts data bytes: at most the line width or 1+15+1+10
  localparam int PW = $clog2(LINE_WIDTH + 28);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CMD  = 3'd1;
  localparam logic [2:0] B_LEAD = 3'd2;
  localparam logic [2:0] B_ZERO = 3'd3;
  localparam logic [2:0] B_DIG  = 3'd4;
  localparam logic [2:0] B_PAD  = 3'd5;

  localparam logic [7:0]    SET_CMD = 8'(SET_ADDRESS_COMMAND);
  localparam logic [PW-1:0] LW_M1   = PW'(LINE_WIDTH - 1);

  logic [2:0]    state_r, state_nxt;
  entry_t        ent_r, ent_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [3:0]    k_r, k_nxt;
  logic          zf_r, zf_nxt;
  logic          pt_done_r, pt_done_nxt;
  logic          ov_r, ov_nxt;
  logic          ocmd_r, ocmd_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          olast_r, olast_nxt;

  logic          can_emit;
  logic [2:0]    field_state;
  logic          zf_eff;
  logic [7:0]    dig;

  assign empty          = !ov_r;
  assign out_is_command = ocmd_r;
  assign out_byte       = obyte_r;
  assign out_last       = olast_r;

  always_comb begin
    can_emit = !ov_r || pop;
    // a point before the top digit of a short field gets a leading zero first
    field_state = (ent_r.point != 2'd0 && {2'b00, ent_r.point} == ent_r.ndig) ? B_ZERO
                                                                             : B_DIG;
    zf_eff = zf_r || (k_r == 4'd1);
    dig    = ent_r.digits[k_r - 4'd1];
  end

  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    pos_nxt     = pos_r;
    k_nxt       = k_r;
    zf_nxt      = zf_r;
    pt_done_nxt = pt_done_r;
    q_rd        = 1'b0;
    ov_nxt      = ov_r && !pop;
    ocmd_nxt    = ocmd_r;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    if (state_r != B_IDLE && can_emit) begin
      ov_nxt    = 1'b1;
      ocmd_nxt  = 1'b0;
      olast_nxt = 1'b0;
      obyte_nxt = CHAR_SPACE;
      pos_nxt   = pos_r + 1'b1;
    end
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_rd      = 1'b1;
          ent_nxt   = q_data;
          zf_nxt    = q_data.zlead;
          state_nxt = B_CMD;
        end
      end
      B_CMD: begin
        if (can_emit) begin
          ocmd_nxt    = 1'b1;
          obyte_nxt   = SET_CMD | (ent_r.row ? ROW1_OFFSET : 8'h00);
          pos_nxt     = '0;
          k_nxt       = ent_r.ndig;
          pt_done_nxt = 1'b0;
          state_nxt   = (ent_r.column != 4'd0) ? B_LEAD : field_state;
        end
      end
      B_LEAD: begin
        if (can_emit && pos_nxt == PW'(ent_r.column)) begin
          state_nxt = field_state;
        end
      end
      B_ZERO: begin
        if (can_emit) begin
          obyte_nxt = CHAR_ZERO;
          zf_nxt    = 1'b1;
          state_nxt = B_DIG;
        end
      end
      B_DIG: begin
        if (can_emit) begin
          if ({2'b00, ent_r.point} == k_r && !pt_done_r) begin
            obyte_nxt   = CHAR_POINT;
            pt_done_nxt = 1'b1;
          end else begin
            pt_done_nxt = 1'b0;
            if (dig == 8'd0) begin
              obyte_nxt = zf_eff ? CHAR_ZERO : CHAR_SPACE;
              zf_nxt    = zf_eff;
            end else begin
              obyte_nxt = CHAR_ZERO + dig;
              zf_nxt    = 1'b1;
            end
            k_nxt = k_r - 4'd1;
            if (k_r == 4'd1) begin
              if (pos_r >= LW_M1) begin
                olast_nxt = 1'b1;
                state_nxt = B_IDLE;
              end else begin
                state_nxt = B_PAD;
              end
            end
          end
        end
      end
      B_PAD: begin
        if (can_emit && pos_r == LW_M1) begin
          olast_nxt = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    ent_r     <= ent_nxt;
    pos_r     <= pos_nxt;
    k_r       <= k_nxt;
    zf_r      <= zf_nxt;
    pt_done_r <= pt_done_nxt;
    ocmd_r    <= ocmd_nxt;
    obyte_r   <= obyte_nxt;
    olast_r   <= olast_nxt;
  end

endmodule

### hdl/decimal_number_line_formatter.sv
// decimal number formatter for one line of a two-row character display
// input side: a queue. a request (row, column, digit count, point position,
// leading-zero flag, 32-bit value) is taken when push is high and full low.
// output side: a queue of display bytes. while empty is low the oldest byte
// sits on out_is_command/out_byte/out_last and pop takes it.
// a run is one set-address command, then LINE_WIDTH or more data bytes;
// out_last marks its final byte.
// the front converts the value by compare and subtract, four steps for each
// of the ten decimal digits; the top digit of the field folds in the digits
// above it. full stays high from taking a request until it is written into
// the queue, so no new request is taken while one is being converted.
// a two-entry queue sits between the converter and the byte sequencer.
// within a run the sequencer emits one byte per cycle while the receiver
// keeps popping.
// a stalled receiver holds the output byte; the sequencer waits, then the
// queue fills, then full stays high. reset empties everything.
module decimal_number_line_formatter #(
  parameter int LINE_WIDTH          = 16,
  parameter int SET_ADDRESS_COMMAND = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_row,
  input  logic [3:0]  in_column,
  input  logic [3:0]  in_digit_count,
  input  logic [1:0]  in_point_position,
  input  logic        in_show_leading_zeros,
  input  logic [31:0] in_value,
  output logic        empty,
  input  logic        pop,
  output logic        out_is_command,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import dnlf_pkg::*;

  logic    q_wr;
  logic    q_rd;
  entry_t  q_wr_data;
  entry_t  q_rd_data;
  qstat_t  q_stat;

  dnlf_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_row                (in_row),
    .in_column             (in_column),
    .in_digit_count        (in_digit_count),
    .in_point_position     (in_point_position),
    .in_show_leading_zeros (in_show_leading_zeros),
    .in_value              (in_value),
    .q_stat                (q_stat),
    .q_wr                  (q_wr),
    .q_entry               (q_wr_data)
  );

  dnlf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  dnlf_back #(
    .LINE_WIDTH          (LINE_WIDTH),
    .SET_ADDRESS_COMMAND (SET_ADDRESS_COMMAND)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_rd_data),
    .q_stat         (q_stat),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .out_is_command (out_is_command),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  // converter only hands over a request when the queue has room
  a_wr_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> !q_stat.full)
    else $error("request written into a full queue");

  // sequencer only takes a request that is there
  a_rd_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_stat.empty)
    else $error("request taken from an empty queue");

  // the set-address command opens a run and never closes it
  a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_command) |-> !out_last)
    else $error("command byte flagged as end of run");

  // after the end of a run the next byte shown is a command
  a_cmd_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_last) |=> (empty || out_is_command))
    else $error("run did not start with a command");

endmodule

### dv/decimal_number_line_formatter_tb.sv
module decimal_number_line_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dnlf_pkg::*;

  localparam int          LINE_WIDTH   = 16;
  localparam logic [7:0]  SET_ADDR_CMD = 8'h80;
  localparam int          N_DIRECTED   = 23;
  localparam int          N_RANDOM     = 207;
  localparam int          HOLDOFF_AT   = 60;
  localparam int          HOLDOFF_LEN  = 400;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 80;

  typedef struct packed {
    logic        row;
    logic [3:0]  column;
    logic [3:0]  digit_count;
    logic [1:0]  point;
    logic        zeros;
    logic [31:0] value;
  } line_req_t;

  typedef struct packed {
    logic       is_cmd;
    logic [7:0] code;
    logic       last;
  } disp_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_row = 1'b0;
  logic [3:0]  in_column = '0;
  logic [3:0]  in_digit_count = '0;
  logic [1:0]  in_point_position = '0;
  logic        in_show_leading_zeros = 1'b0;
  logic [31:0] in_value = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_is_command;
  logic [7:0]  out_byte;
  logic        out_last;

  disp_byte_t  expected_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned requests_taken = 0;
  int unsigned burst_left = 1;

  // field text is what follows the column spaces; empty text means use the predictor
  line_req_t directed_req[N_DIRECTED] = '{
    '{1'b0, 4'd0,  4'd10, 2'd0, 1'b1, 32'd0},
    '{1'b1, 4'd0,  4'd10, 2'd0, 1'b0, 32'hFFFF_FFFF},
    '{1'b0, 4'd15, 4'd10, 2'd1, 1'b1, 32'd0},
    '{1'b1, 4'd0,  4'd1,  2'd0, 1'b0, 32'hFFFF_FFFF},
    '{1'b0, 4'd0,  4'd1,  2'd1, 1'b0, 32'd7},
    '{1'b0, 4'd0,  4'd0,  2'd0, 1'b1, 32'd123},
    '{1'b1, 4'd0,  4'd15, 2'd2, 1'b1, 32'd0},
    '{1'b0, 4'd0,  4'd2,  2'd3, 1'b1, 32'd5},
    '{1'b0, 4'd0,  4'd3,  2'd3, 1'b0, 32'd999},
    '{1'b0, 4'd0,  4'd1,  2'd0, 1'b0, 32'd0},
    '{1'b1, 4'd7,  4'd2,  2'd2, 1'b0, 32'd42},
    '{1'b0, 4'd3,  4'd11, 2'd0, 1'b1, 32'd1000000000},
    '{1'b0, 4'd0,  4'd10, 2'd0, 1'b0, 32'd0},
    '{1'b1, 4'd5,  4'd5,  2'd0, 1'b0, 32'd12},
    '{1'b0, 4'd0,  4'd2,  2'd0, 1'b0, 32'd1000},
    '{1'b0, 4'd0,  4'd2,  2'd0, 1'b0, 32'd25600},
    '{1'b1, 4'd2,  4'd4,  2'd2, 1'b0, 32'd5},
    '{1'b0, 4'd0,  4'd4,  2'd3, 1'b0, 32'd50},
    '{1'b0, 4'd9,  4'd9,  2'd1, 1'b0, 32'd999999999},
    '{1'b1, 4'd15, 4'd12, 2'd3, 1'b0, 32'd1234567},
    '{1'b0, 4'd0,  4'd3,  2'd1, 1'b1, 32'd4000},
    '{1'b1, 4'd10, 4'd14, 2'd1, 1'b0, 32'h8000_0000},
    '{1'b0, 4'd4,  4'd6,  2'd2, 1'b0, 32'd100}
  };

  string directed_text[N_DIRECTED] = '{
    "0000000000", "4294967295", "000000000.0", "/", "0.7", "0000000123",
    "00000000.00", "05", "0.999", "0", "0.42", "1000000000",
    "", "", "", "", "", "", "", "", "", "", ""
  };

  decimal_number_line_formatter #(
    .LINE_WIDTH          (LINE_WIDTH),
    .SET_ADDRESS_COMMAND (128)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_row                (in_row),
    .in_column             (in_column),
    .in_digit_count        (in_digit_count),
    .in_point_position     (in_point_position),
    .in_show_leading_zeros (in_show_leading_zeros),
    .in_value              (in_value),
    .empty                 (empty),
    .pop                   (pop),
    .out_is_command        (out_is_command),
    .out_byte              (out_byte),
    .out_last              (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void append_run(input disp_byte_t run[$]);
    foreach (run[i]) begin
      run[i].last = (i == run.size() - 1);
      expected_bytes.push_back(run[i]);
    end
  endfunction

  function automatic void append_typed(input line_req_t r, input string text);
    disp_byte_t  run[$];
    int unsigned pos;
    run.push_back(disp_byte_t'{1'b1, r.row ? 8'hC0 : 8'h80, 1'b0});
    for (pos = 0; pos < r.column; pos++)
      run.push_back(disp_byte_t'{1'b0, CHAR_SPACE, 1'b0});
    for (int i = 0; i < text.len(); i++)
      run.push_back(disp_byte_t'{1'b0, text[i], 1'b0});
    pos += text.len();
    for (; pos < LINE_WIDTH; pos++)
      run.push_back(disp_byte_t'{1'b0, CHAR_SPACE, 1'b0});
    append_run(run);
  endfunction

  // expected byte run for one request
  function automatic void format_line(input line_req_t r);
    disp_byte_t  run[$];
    logic [3:0]  ndig;
    logic        shown;
    logic [31:0] rest;
    logic [31:0] scale;
    logic [31:0] quo;
    logic [7:0]  ch;
    int unsigned pos;
    ndig  = (r.digit_count == 4'd0 || r.digit_count > 4'd10) ? 4'd10 : r.digit_count;
    shown = r.zeros;
    rest  = r.value;
    pos   = 0;
    run.push_back(disp_byte_t'{1'b1, SET_ADDR_CMD | (r.row ? ROW1_OFFSET : 8'h00), 1'b0});
    for (; pos < r.column; pos++)
      run.push_back(disp_byte_t'{1'b0, CHAR_SPACE, 1'b0});
    // point before the top digit gets a leading zero
    if (r.point != 2'd0 && r.point == ndig) begin
      run.push_back(disp_byte_t'{1'b0, CHAR_ZERO, 1'b0});
      pos++;
      shown = 1'b1;
    end
    for (int k = ndig; k >= 1; k--) begin
      scale = 32'd1;
      for (int j = 1; j < k; j++)
        scale = scale * 32'd10;
      quo  = rest / scale;
      rest = rest % scale;
      if (r.point == k) begin
        run.push_back(disp_byte_t'{1'b0, CHAR_POINT, 1'b0});
        pos++;
      end
      if (k == 1)
        shown = 1'b1;
      // an overflowing top digit keeps only its low byte
      ch = quo[7:0];
      if (ch == 8'd0) begin
        run.push_back(disp_byte_t'{1'b0, shown ? CHAR_ZERO : CHAR_SPACE, 1'b0});
      end else begin
        shown = 1'b1;
        ch = ch + CHAR_ZERO;
        run.push_back(disp_byte_t'{1'b0, ch, 1'b0});
      end
      pos++;
    end
    for (; pos < LINE_WIDTH; pos++)
      run.push_back(disp_byte_t'{1'b0, CHAR_SPACE, 1'b0});
    append_run(run);
  endfunction

  function automatic line_req_t random_request();
    line_req_t   r;
    int unsigned eff;
    longint      scale;
    r.row    = 1'($urandom_range(0, 1));
    r.column = 4'($urandom_range(0, 15));
    // 16 wraps to 0, which acts as a full field
    if ($urandom_range(0, 4) == 0)
      r.digit_count = 4'($urandom_range(11, 16));
    else
      r.digit_count = 4'($urandom_range(1, 10));
    r.point = 2'($urandom_range(0, 3));
    r.zeros = 1'($urandom_range(0, 1));
    eff = (r.digit_count == 4'd0 || r.digit_count > 4'd10) ? 10 : r.digit_count;
    case ($urandom_range(0, 4))
      0: r.value = $urandom;
      1: r.value = $urandom_range(0, 999);
      2: begin
        scale = 1;
        repeat (eff) scale = scale * 10;
        r.value = 32'(longint'($urandom) % scale);
      end
      3: begin
        scale = 1;
        repeat ($urandom_range(0, 9)) scale = scale * 10;
        r.value = 32'(scale + $urandom_range(0, 2) - 1);
      end
      default: begin
        scale = 1;
        repeat ($urandom_range(0, 9)) scale = scale * 10;
        r.value = 32'(scale * $urandom_range(0, 9));
      end
    endcase
    return r;
  endfunction

  task automatic send_request(input line_req_t r, input string text, input bit final_item);
    int unsigned gap;
    in_row                <= r.row;
    in_column             <= r.column;
    in_digit_count        <= r.digit_count;
    in_point_position     <= r.point;
    in_show_leading_zeros <= r.zeros;
    in_value              <= r.value;
    push                  <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    requests_taken++;
    if (text.len() == 0)
      format_line(r);
    else
      append_typed(r, text);
    if (burst_left > 0)
      burst_left--;
    if (final_item || burst_left == 0) begin
      gap        = final_item ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (final_item || gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic void check_byte();
    disp_byte_t want;
    if (expected_bytes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t: unexpected byte cmd=%0b byte=%h last=%0b",
                 $time, out_is_command, out_byte, out_last);
    end else begin
      want = expected_bytes.pop_front();
      if (out_is_command !== want.is_cmd || out_byte !== want.code ||
          out_last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t: expected cmd=%0b byte=%h last=%0b, got cmd=%0b byte=%h last=%0b",
                   $time, want.is_cmd, want.code, want.last,
                   out_is_command, out_byte, out_last);
      end
    end
  endfunction

  // receiver: rotating stall patterns plus one long hold-off
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit          held;
    bit          ready;
    rx_cycle  = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && empty === 1'b0)
        check_byte();
      rx_cycle++;
      if (!held && requests_taken >= HOLDOFF_AT) begin
        held      = 1'b1;
        hold_left = HOLDOFF_LEN;
      end
      if (hold_left != 0) begin
        ready = 1'b0;
        hold_left--;
      end else begin
        case ((rx_cycle / 64) % 4)
          0:       ready = 1'b1;
          1:       ready = 1'($urandom_range(0, 1));
          2:       ready = (rx_cycle % 8) < 3;
          default: ready = ($urandom_range(0, 7) != 0);
        endcase
      end
      pop <= ready;
    end
  end

  // watchdog on cycles with no request and no byte taken
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    line_req_t r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      send_request(directed_req[i], directed_text[i], 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      r = random_request();
      send_request(r, "", i == N_RANDOM - 1);
    end
    while (expected_bytes.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
hdl/dnlf_pkg.sv
hdl/dnlf_front.sv
hdl/dnlf_queue.sv
hdl/dnlf_back.sv
hdl/decimal_number_line_formatter.sv
dv/decimal_number_line_formatter_tb.sv
